// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the bar meter RTL.
// Depends on nothing; simulation builds see the checks, synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define SBBM_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("sbbm: property failed");
// Flag a condition that must never be seen outside reset
`define SBBM_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error("sbbm: forbidden condition seen");
`else
`define SBBM_ASSERT(lbl, clk_s, rstn_s, prop)
`define SBBM_NEVER(lbl, clk_s, rstn_s, cond)
`endif
`endif

// ===== rtl/core/sbbm_pkg.sv =====
// Shared constants, word types and control structs of the spectrum bar meter.
// No dependencies; every RTL module file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package sbbm_pkg;

  // Design constants
  localparam int TRANSFORM_POINTS = 512;
  localparam int BAND_COUNT       = 8;
  localparam int BAR_HEIGHT       = 8;
  localparam int EDGE_COUNT       = 8;
  localparam int ROWS_SHOWN       = (BAR_HEIGHT < 8) ? BAR_HEIGHT : 8;

  // Field and datapath widths
  localparam int PART_W      = 20;
  localparam int BIN_W       = 8;
  localparam int EDGE_W      = 9;
  localparam int EDGE_IDX_W  = $clog2(EDGE_COUNT);
  localparam int CFG_IDX_W   = EDGE_IDX_W + 1;
  localparam int SQ_W        = 2 * PART_W;
  localparam int ROOT_W      = PART_W;
  localparam int SQRT_STEPS  = ROOT_W / 2;
  localparam int STEP_CNT_W  = $clog2(SQRT_STEPS);
  localparam int SUM_W       = 28;
  localparam int LEVEL_W     = 4;
  localparam int HALF_W      = $clog2(BAR_HEIGHT / 2 + 1);
  localparam int BIN_CMP_W   = 13;
  localparam int COL_W       = $clog2(BAND_COUNT);
  localparam int ROW_W       = $clog2(ROWS_SHOWN);
  localparam int THR_W       = 5;

  // Arithmetic constants
  localparam int NOISE_RAW      = 80;
  localparam int FULL_SCALE_RAW = 9600;
  localparam int AVERAGE_DIV    = 2;
  localparam int LEVEL_MAX      = 15;
  localparam int BIN_LIMIT      = TRANSFORM_POINTS / 2 - 1;
  localparam int RED_ROWS       = BAR_HEIGHT / 8;
  localparam int YELLOW_ROWS    = BAR_HEIGHT / 2;

  // Band edge values after reset
  localparam logic [EDGE_W-1:0] EDGE_RESET [EDGE_COUNT] =
    '{9'd2, 9'd4, 9'd8, 9'd16, 9'd32, 9'd64, 9'd128, 9'd255};

  // Pixel color codes
  localparam logic [1:0] COLOR_OFF    = 2'd0;
  localparam logic [1:0] COLOR_RED    = 2'd1;
  localparam logic [1:0] COLOR_YELLOW = 2'd2;
  localparam logic [1:0] COLOR_GREEN  = 2'd3;

  // Input word: one FFT bin
  typedef struct packed {
    logic signed [PART_W-1:0] real_part;
    logic signed [PART_W-1:0] imag_part;
    logic [BIN_W-1:0]         bin_index;
    logic                     frame_end;
  } sbbm_in_t;

  // Output word: one pixel
  typedef struct packed {
    logic [2:0] pixel_row;
    logic [2:0] pixel_column;
    logic [1:0] pixel_color;
    logic       grid_last;
  } sbbm_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul_re;
    logic mul_im;
    logic sqrt_start;
    logic sqrt_step;
    logic acc;
    logic frame_close;
    logic grid_step;
  } sbbm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sqrt_last;
    logic frame_end;
    logic phase;
    logic grid_done;
  } sbbm_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/sbbm_sqrt.sv =====
// Iterative floor square root, two root bits per cycle while step is high (restoring digit recurrence).
// Depends on sbbm_pkg for widths and step count.
`timescale 1ns / 1ps
`default_nettype none
module sbbm_sqrt (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic                           step,
  input  wire logic [sbbm_pkg::SQ_W-1:0]      radicand,
  output logic      [sbbm_pkg::ROOT_W-1:0]    root,
  output logic                                last_step
);

  localparam int REM_W = sbbm_pkg::ROOT_W + 3;

  logic [sbbm_pkg::SQ_W-1:0]       rad_r, rad_nxt;
  logic [REM_W-1:0]                rem_r, rem_nxt;
  logic [sbbm_pkg::ROOT_W-1:0]     root_r, root_nxt;
  logic [sbbm_pkg::STEP_CNT_W-1:0] cnt_r;
  logic [REM_W-1:0]                trial;

  // Two digit steps: shift in a radicand pair, try subtracting 4*root+1
  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    trial    = '0;
    for (int i = 0; i < 2; i++) begin
      rem_nxt = {rem_nxt[REM_W-3:0], rad_nxt[sbbm_pkg::SQ_W-1 -: 2]};
      rad_nxt = {rad_nxt[sbbm_pkg::SQ_W-3:0], 2'b00};
      trial   = REM_W'({root_nxt, 2'b01});
      if (rem_nxt >= trial) begin
        rem_nxt  = rem_nxt - trial;
        root_nxt = {root_nxt[sbbm_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        root_nxt = {root_nxt[sbbm_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + sbbm_pkg::STEP_CNT_W'(1);
    end
  end

  // Load or advance the recurrence
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (step) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign root      = root_r;
  assign last_step = (cnt_r == sbbm_pkg::STEP_CNT_W'(sbbm_pkg::SQRT_STEPS - 1));

endmodule
`default_nettype wire

// ===== rtl/core/sbbm_datapath.sv =====
// Datapath of the bar meter: magnitude, band sums, levels, edge registers, pixel output.
// Depends on sbbm_pkg and sbbm_sqrt.
`timescale 1ns / 1ps
`default_nettype none
module sbbm_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire sbbm_pkg::sbbm_cmd_t                 cmd,
  output sbbm_pkg::sbbm_stat_t                     stat,
  input  wire sbbm_pkg::sbbm_in_t                  in_item,
  input  wire logic                                cfg_we,
  input  wire logic [sbbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sbbm_pkg::EDGE_W-1:0]         cfg_wdata,
  output logic                                     out_valid,
  output sbbm_pkg::sbbm_out_t                      out_item
);

  // Height over full scale, clamped to the bar and halved
  function automatic logic [sbbm_pkg::HALF_W-1:0] half_height(
    input logic [sbbm_pkg::SUM_W-1:0] s
  );
    logic [sbbm_pkg::HALF_W-1:0] h;
    h = '0;
    for (int j = 1; j <= sbbm_pkg::BAR_HEIGHT / sbbm_pkg::AVERAGE_DIV; j++) begin
      if (s >= sbbm_pkg::SUM_W'(sbbm_pkg::AVERAGE_DIV * j * sbbm_pkg::FULL_SCALE_RAW)) begin
        h = sbbm_pkg::HALF_W'(j);
      end
    end
    return h;
  endfunction

  sbbm_pkg::sbbm_in_t               item_r;
  logic [sbbm_pkg::SQ_W-1:0]        prod_re_r;
  logic [sbbm_pkg::SQ_W-1:0]        prod_im_r;
  logic [sbbm_pkg::EDGE_W-1:0]      edge_r  [sbbm_pkg::EDGE_COUNT];
  logic [sbbm_pkg::SUM_W-1:0]       sum_r   [sbbm_pkg::BAND_COUNT];
  logic [sbbm_pkg::SUM_W-1:0]       sum_nxt [sbbm_pkg::BAND_COUNT];
  logic [sbbm_pkg::LEVEL_W-1:0]     level_r   [sbbm_pkg::BAND_COUNT];
  logic [sbbm_pkg::LEVEL_W-1:0]     level_nxt [sbbm_pkg::BAND_COUNT];
  logic                             phase_r;
  logic [sbbm_pkg::ROW_W-1:0]       row_r;
  logic [sbbm_pkg::COL_W-1:0]       col_r;
  logic                             out_valid_r;
  sbbm_pkg::sbbm_out_t              out_r;

  logic [sbbm_pkg::PART_W-1:0]      re_bits, im_bits, abs_re, abs_im, mul_a;
  logic [sbbm_pkg::SQ_W-1:0]        product;
  logic [sbbm_pkg::SQ_W-1:0]        radicand;
  logic [sbbm_pkg::ROOT_W-1:0]      root;
  logic                             sqrt_last;
  logic [sbbm_pkg::EDGE_W-1:0]      bin9;
  logic                             bin_ok, mag_ok;
  logic [sbbm_pkg::EDGE_W-1:0]      lower [sbbm_pkg::BAND_COUNT];
  logic [sbbm_pkg::SUM_W:0]         sum_add [sbbm_pkg::BAND_COUNT];
  logic [sbbm_pkg::LEVEL_W:0]       level_add [sbbm_pkg::BAND_COUNT];
  logic                             grid_done;
  logic [sbbm_pkg::LEVEL_W-1:0]     pix_level;
  logic [sbbm_pkg::THR_W-1:0]       pix_thr;
  logic                             pix_lit;
  logic [1:0]                       pix_color;

  // Absolute values of the captured bin, one shared squarer
  assign re_bits  = item_r.real_part;
  assign im_bits  = item_r.imag_part;
  assign abs_re   = re_bits[sbbm_pkg::PART_W-1] ? (~re_bits + sbbm_pkg::PART_W'(1)) : re_bits;
  assign abs_im   = im_bits[sbbm_pkg::PART_W-1] ? (~im_bits + sbbm_pkg::PART_W'(1)) : im_bits;
  assign mul_a    = cmd.mul_im ? abs_im : abs_re;
  assign product  = mul_a * mul_a;
  assign radicand = prod_re_r + prod_im_r;

  sbbm_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.sqrt_start),
    .step      (cmd.sqrt_step),
    .radicand  (radicand),
    .root      (root),
    .last_step (sqrt_last)
  );

  // Capture the input word and the squares
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.mul_re) begin
      prod_re_r <= product;
    end
    if (cmd.mul_im) begin
      prod_im_r <= product;
    end
  end

  // Bin qualification
  assign bin9   = {1'b0, item_r.bin_index};
  assign bin_ok = (item_r.bin_index != '0) &&
                  (sbbm_pkg::BIN_CMP_W'(item_r.bin_index) <
                   sbbm_pkg::BIN_CMP_W'(sbbm_pkg::BIN_LIMIT));
  assign mag_ok = root > sbbm_pkg::ROOT_W'(sbbm_pkg::NOISE_RAW);

  // Per-band lanes: accumulate, close the frame, clear after the grid
  always_comb begin
    lower[0] = '0;
    for (int k = 1; k < sbbm_pkg::BAND_COUNT; k++) begin
      lower[k] = edge_r[k-1];
    end
    for (int k = 0; k < sbbm_pkg::BAND_COUNT; k++) begin
      sum_add[k]   = {1'b0, sum_r[k]} + (sbbm_pkg::SUM_W + 1)'(root);
      level_add[k] = {1'b0, level_r[k]} + (sbbm_pkg::LEVEL_W + 1)'(half_height(sum_r[k]));
      sum_nxt[k]   = sum_r[k];
      level_nxt[k] = level_r[k];
      if (cmd.acc && bin_ok && mag_ok && (bin9 >= lower[k]) && (bin9 < edge_r[k])) begin
        sum_nxt[k] = sum_add[k][sbbm_pkg::SUM_W] ? '1 : sum_add[k][sbbm_pkg::SUM_W-1:0];
      end
      if (cmd.frame_close) begin
        sum_nxt[k]   = '0;
        level_nxt[k] = (level_add[k] > (sbbm_pkg::LEVEL_W + 1)'(sbbm_pkg::LEVEL_MAX)) ?
                       sbbm_pkg::LEVEL_W'(sbbm_pkg::LEVEL_MAX) :
                       level_add[k][sbbm_pkg::LEVEL_W-1:0];
      end
      if (cmd.grid_step && grid_done) begin
        level_nxt[k] = '0;
      end
    end
  end

  // Grid scan position
  assign grid_done = (row_r == sbbm_pkg::ROW_W'(sbbm_pkg::ROWS_SHOWN - 1)) &&
                     (col_r == sbbm_pkg::COL_W'(sbbm_pkg::BAND_COUNT - 1));

  // Pixel color of the current scan position
  assign pix_level = level_r[col_r];
  assign pix_thr   = sbbm_pkg::THR_W'(sbbm_pkg::BAR_HEIGHT) - sbbm_pkg::THR_W'(row_r);
  assign pix_lit   = sbbm_pkg::THR_W'(pix_level) >= pix_thr;

  always_comb begin
    if (!pix_lit) begin
      pix_color = sbbm_pkg::COLOR_OFF;
    end else if (sbbm_pkg::THR_W'(row_r) < sbbm_pkg::THR_W'(sbbm_pkg::RED_ROWS)) begin
      pix_color = sbbm_pkg::COLOR_RED;
    end else if (sbbm_pkg::THR_W'(row_r) < sbbm_pkg::THR_W'(sbbm_pkg::YELLOW_ROWS)) begin
      pix_color = sbbm_pkg::COLOR_YELLOW;
    end else begin
      pix_color = sbbm_pkg::COLOR_GREEN;
    end
  end

  // Architectural state: edges, sums, levels, phase, scan counters, strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < sbbm_pkg::EDGE_COUNT; k++) begin
        edge_r[k] <= sbbm_pkg::EDGE_RESET[k];
      end
      for (int k = 0; k < sbbm_pkg::BAND_COUNT; k++) begin
        sum_r[k]   <= '0;
        level_r[k] <= '0;
      end
      phase_r     <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index < sbbm_pkg::CFG_IDX_W'(sbbm_pkg::EDGE_COUNT))) begin
        edge_r[cfg_index[sbbm_pkg::EDGE_IDX_W-1:0]] <= cfg_wdata;
      end
      for (int k = 0; k < sbbm_pkg::BAND_COUNT; k++) begin
        sum_r[k]   <= sum_nxt[k];
        level_r[k] <= level_nxt[k];
      end
      if (cmd.frame_close) begin
        phase_r <= ~phase_r;
      end
      if (cmd.grid_step) begin
        if (col_r == sbbm_pkg::COL_W'(sbbm_pkg::BAND_COUNT - 1)) begin
          col_r <= '0;
          row_r <= grid_done ? '0 : row_r + sbbm_pkg::ROW_W'(1);
        end else begin
          col_r <= col_r + sbbm_pkg::COL_W'(1);
        end
      end
      out_valid_r <= cmd.grid_step;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.grid_step) begin
      out_r.pixel_row    <= 3'(row_r);
      out_r.pixel_column <= 3'(col_r);
      out_r.pixel_color  <= pix_color;
      out_r.grid_last    <= grid_done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_item       = out_r;
  assign stat.sqrt_last = sqrt_last;
  assign stat.frame_end = item_r.frame_end;
  assign stat.phase     = phase_r;
  assign stat.grid_done = grid_done;

endmodule
`default_nettype wire

// ===== rtl/core/sbbm_ctrl.sv =====
// Sequencer of the bar meter: steps one bin through square, root and accumulate,
// then, on a frame-end bin, frame close and, every second frame, grid scan. Depends on sbbm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbbm_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire sbbm_pkg::sbbm_stat_t  stat,
  output logic                       busy,
  output sbbm_pkg::sbbm_cmd_t        cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL_RE = 3'd1;
  localparam logic [2:0] ST_MUL_IM = 3'd2;
  localparam logic [2:0] ST_LOAD   = 3'd3;
  localparam logic [2:0] ST_ROOT   = 3'd4;
  localparam logic [2:0] ST_ACC    = 3'd5;
  localparam logic [2:0] ST_CLOSE  = 3'd6;
  localparam logic [2:0] ST_GRID   = 3'd7;

  logic [2:0] state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL_RE;
        end
      end
      ST_MUL_RE: begin
        cmd.mul_re = 1'b1;
        state_nxt  = ST_MUL_IM;
      end
      ST_MUL_IM: begin
        cmd.mul_im = 1'b1;
        state_nxt  = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_last) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = stat.frame_end ? ST_CLOSE : ST_IDLE;
      end
      ST_CLOSE: begin
        cmd.frame_close = 1'b1;
        // phase still holds its old value here: one means this frame emits
        state_nxt       = stat.phase ? ST_GRID : ST_IDLE;
      end
      ST_GRID: begin
        cmd.grid_step = 1'b1;
        if (stat.grid_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/spectrum_band_bar_meter.sv =====
// Eight-band spectrum bar meter: one FFT bin per start, taken only while busy is low;
// the 20-bit root is formed at two bits a cycle, after both parts are squared on one multiplier.
// A frame-end bin adds a frame-close state; every second frame then emits 64 pixels, one per cycle,
// each strobe registered from a grid-scan state after frame close; the receiver cannot stall.
// Synchronous active-low reset: edges to defaults, sums, levels and phase to zero, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module spectrum_band_bar_meter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire sbbm_pkg::sbbm_in_t                in_item,
  output logic                                   out_valid,
  output sbbm_pkg::sbbm_out_t                    out_item,
  input  wire logic                              cfg_we,
  input  wire logic [sbbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sbbm_pkg::EDGE_W-1:0]       cfg_wdata
);

  sbbm_pkg::sbbm_cmd_t  cmd;
  sbbm_pkg::sbbm_stat_t stat;

  sbbm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  sbbm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // An accepted word always occupies the block on the next cycle
  `SBBM_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
  // Pixels only come out of a grid scan, which holds busy
  `SBBM_NEVER(a_pixel_from_scan, clk, rst_n, out_valid && !$past(busy))
  // The grid ends at its last pixel
  `SBBM_ASSERT(a_grid_ends, clk, rst_n, (out_valid && out_item.grid_last) |=> !out_valid)

endmodule
`default_nettype wire

// ===== tb/spectrum_band_bar_meter_tb.sv =====
// Self-checking bench for the spectrum band bar meter: streams FFT bin words, predicts every pixel.
// Depends on sbbm_pkg and the spectrum_band_bar_meter RTL; needs no files or arguments.
`timescale 1ns / 1ps
module spectrum_band_bar_meter_tb;
  import sbbm_pkg::*;

  typedef enum int {EDGES_RESET, EDGES_SORTED, EDGES_SCRAMBLED, EDGES_EXTREME} edge_style_e;

  localparam int CLK_HALF = 6;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam int SETTLE_CYCLES = 80;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  sbbm_in_t             in_item;
  logic                 out_valid;
  sbbm_out_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [EDGE_W-1:0]    cfg_wdata;

  // Predicted block state
  logic [EDGE_W-1:0]  mdl_edge  [EDGE_COUNT];
  logic [SUM_W-1:0]   mdl_sum   [EDGE_COUNT];
  logic [LEVEL_W-1:0] mdl_level [EDGE_COUNT];
  bit                 mdl_phase;

  sbbm_out_t          pixel_q [$];
  sbbm_out_t          want;
  logic [EDGE_W-1:0]  edge_plan [EDGE_COUNT];
  edge_style_e        phase_style [6] =
    '{EDGES_RESET, EDGES_SORTED, EDGES_SCRAMBLED, EDGES_SORTED, EDGES_EXTREME, EDGES_SCRAMBLED};

  bit gaps_on;
  int errors;
  int bins_sent;
  int pixels_seen;
  int grids_expected;
  int edge_sets;

  spectrum_band_bar_meter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Bound the run in case the block hangs
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [PART_W-1:0] part_abs(input logic [PART_W-1:0] v);
    return v[PART_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Floor square root, one result bit per pass from the top
  function automatic logic [ROOT_W-1:0] floor_root(input logic [SQ_W-1:0] x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r[ROOT_W-1:0];
  endfunction

  function automatic sbbm_in_t make_word(input int re, input int im,
                                         input int bin, input bit last);
    sbbm_in_t w;
    w.real_part = re[PART_W-1:0];
    w.imag_part = im[PART_W-1:0];
    w.bin_index = bin[BIN_W-1:0];
    w.frame_end = last;
    return w;
  endfunction

  // Mix of near-threshold, mid-scale, full-range and extreme parts
  function automatic int rand_part();
    int pick;
    int span;
    int v;
    pick = $urandom_range(99);
    if (pick < 12) begin
      span = 90;
      v = int'($urandom_range(0, 2 * span)) - span;
    end else if (pick < 70) begin
      span = $urandom_range(1, 16000);
      v = int'($urandom_range(0, 2 * span)) - span;
    end else if (pick < 88) begin
      v = $urandom;
    end else begin
      case ($urandom_range(2))
        0: v = -524288;
        1: v = 524287;
        default: v = 0;
      endcase
    end
    return v;
  endfunction

  // Fold one accepted bin word into the predicted state; queue the grid when one is due
  task automatic absorb_bin(input sbbm_in_t w);
    logic [PART_W-1:0]  re;
    logic [PART_W-1:0]  im;
    logic [SQ_W-1:0]    sq;
    logic [ROOT_W-1:0]  mag;
    logic [SUM_W:0]     s;
    logic [EDGE_W-1:0]  lo;
    logic [SUM_W-1:0]   h;
    logic [LEVEL_W:0]   lv;
    sbbm_out_t          px;
    re  = part_abs(w.real_part);
    im  = part_abs(w.imag_part);
    sq  = re * re + im * im;
    mag = floor_root(sq);
    if (w.bin_index != 0 && w.bin_index < BIN_LIMIT && mag > NOISE_RAW) begin
      for (int k = 0; k < BAND_COUNT; k++) begin
        lo = (k == 0) ? '0 : mdl_edge[k-1];
        if ({1'b0, w.bin_index} >= lo && {1'b0, w.bin_index} < mdl_edge[k]) begin
          s = mdl_sum[k] + mag;
          mdl_sum[k] = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
        end
      end
    end
    if (w.frame_end) begin
      // Close the frame: scale, clamp and halve each sum into its level
      for (int k = 0; k < BAND_COUNT; k++) begin
        h = mdl_sum[k] / SUM_W'(FULL_SCALE_RAW);
        if (h > BAR_HEIGHT) h = SUM_W'(BAR_HEIGHT);
        lv = {1'b0, mdl_level[k]} + (LEVEL_W + 1)'(h / SUM_W'(AVERAGE_DIV));
        mdl_level[k] = (lv > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : lv[LEVEL_W-1:0];
        mdl_sum[k] = '0;
      end
      mdl_phase ^= 1'b1;
      if (!mdl_phase) begin
        for (int r = 0; r < ROWS_SHOWN; r++) begin
          for (int c = 0; c < BAND_COUNT; c++) begin
            px.pixel_row    = r[2:0];
            px.pixel_column = c[2:0];
            if (mdl_level[c] >= BAR_HEIGHT - r) begin
              if (r < RED_ROWS) px.pixel_color = COLOR_RED;
              else if (r < YELLOW_ROWS) px.pixel_color = COLOR_YELLOW;
              else px.pixel_color = COLOR_GREEN;
            end else begin
              px.pixel_color = COLOR_OFF;
            end
            px.grid_last = (r == ROWS_SHOWN - 1 && c == BAND_COUNT - 1);
            pixel_q.push_back(px);
          end
        end
        for (int k = 0; k < EDGE_COUNT; k++) mdl_level[k] = '0;
        grids_expected++;
      end
    end
  endtask

  // Offer one bin word, with an occasional idle gap once the block is free
  task automatic push_word(input sbbm_in_t w);
    @(posedge clk);
    if (gaps_on && $urandom_range(99) < 15) begin
      while (busy) @(posedge clk);
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    absorb_bin(w);
    bins_sent++;
  endtask

  task automatic drain_pixels();
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  // Hold off until every pixel has come and the block has gone quiet
  task automatic quiesce();
    drain_pixels();
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write every index: the edge registers from the plan, the unused ones with junk
  task automatic load_band_edges();
    @(posedge clk);
    for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      if (i < EDGE_COUNT) cfg_wdata <= edge_plan[i];
      else cfg_wdata <= EDGE_W'($urandom_range(0, 511));
      @(posedge clk);
      if (i < EDGE_COUNT) mdl_edge[i] = edge_plan[i];
    end
    cfg_we <= 1'b0;
    edge_sets++;
  endtask

  task automatic pick_edges(input edge_style_e style);
    logic [EDGE_W-1:0] tmp;
    int j;
    for (int i = 0; i < EDGE_COUNT; i++) begin
      case (style)
        EDGES_RESET:   edge_plan[i] = EDGE_RESET[i];
        EDGES_EXTREME: edge_plan[i] = $urandom_range(1) ? 9'd256 : 9'd0;
        default:       edge_plan[i] = EDGE_W'($urandom_range(0, 256));
      endcase
    end
    // Sort into nondecreasing order for well-formed band layouts
    if (style == EDGES_SORTED) begin
      for (int i = 1; i < EDGE_COUNT; i++) begin
        tmp = edge_plan[i];
        j = i - 1;
        while (j >= 0 && edge_plan[j] > tmp) begin
          edge_plan[j+1] = edge_plan[j];
          j--;
        end
        edge_plan[j+1] = tmp;
      end
    end
  endtask

  // Mostly ascending frames with random content; the rest scattered bins
  task automatic run_random_frames(input int quota);
    int count;
    int n;
    int bin;
    count = 0;
    while (count < quota) begin
      if ($urandom_range(99) < 80) begin
        n = $urandom_range(1, 12);
        bin = $urandom_range(0, 120);
        for (int k = 0; k < n; k++) begin
          push_word(make_word(rand_part(), rand_part(), bin, k == n - 1));
          bin = bin + $urandom_range(1, 30);
          if (bin > 255) bin = 255;
        end
      end else begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
          push_word(make_word(rand_part(), rand_part(), $urandom_range(0, 255), k == n - 1));
      end
      count += n;
    end
  endtask

  // Noise floor, DC drop, full-scale parts and clamping at reset edges
  task automatic test_default_bands();
    push_word(make_word(-524288, -524288, 0, 1'b0));
    push_word(make_word(19120, 0, 200, 1'b0));
    push_word(make_word(81, 0, 201, 1'b0));
    push_word(make_word(19120, 0, 100, 1'b0));
    push_word(make_word(0, -80, 101, 1'b0));
    push_word(make_word(524287, -524288, 1, 1'b0));
    push_word(make_word(-524288, 524287, 3, 1'b1));
    push_word(make_word(-524288, -524288, 1, 1'b0));
    push_word(make_word(0, -524288, 2, 1'b0));
    push_word(make_word(-30000, 40000, 5, 1'b0));
    push_word(make_word(0, 0, 254, 1'b1));
  endtask

  // Edges at both ends of their range, then unordered edges with overlap and empty bands
  task automatic test_edge_extremes();
    quiesce();
    for (int i = 0; i < EDGE_COUNT; i++) edge_plan[i] = 9'd256;
    load_band_edges();
    push_word(make_word(524287, 524287, 255, 1'b0));
    push_word(make_word(50000, 0, 254, 1'b1));
    push_word(make_word(0, -40000, 128, 1'b1));
    quiesce();
    for (int i = 0; i < EDGE_COUNT; i++) edge_plan[i] = 9'd0;
    load_band_edges();
    push_word(make_word(524287, -524288, 10, 1'b1));
    push_word(make_word(0, 0, 0, 1'b1));
    quiesce();
    edge_plan = '{9'd50, 9'd10, 9'd100, 9'd100, 9'd100, 9'd100, 9'd100, 9'd100};
    load_band_edges();
    push_word(make_word(-524288, 0, 20, 1'b1));
    push_word(make_word(30000, 0, 60, 1'b1));
  endtask

  // Random frames across several edge layouts, one phase without gaps
  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      quiesce();
      pick_edges(phase_style[ph]);
      load_band_edges();
      gaps_on = (ph != 3);
      run_random_frames(35);
      if (ph == 2) drain_pixels();
      run_random_frames(32);
    end
    gaps_on = 1'b1;
  endtask

  // Compare each strobed pixel with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: pixel with none expected: row %0d col %0d color %0d last %0d",
                 $time, out_item.pixel_row, out_item.pixel_column, out_item.pixel_color,
                 out_item.grid_last);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        pixels_seen++;
        if (out_item.pixel_row !== want.pixel_row) begin
          $display("%0t: pixel_row expected %0d actual %0d", $time,
                   want.pixel_row, out_item.pixel_row);
          errors++;
        end
        if (out_item.pixel_column !== want.pixel_column) begin
          $display("%0t: pixel_column expected %0d actual %0d", $time,
                   want.pixel_column, out_item.pixel_column);
          errors++;
        end
        if (out_item.pixel_color !== want.pixel_color) begin
          $display("%0t: pixel_color at row %0d col %0d expected %0d actual %0d", $time,
                   want.pixel_row, want.pixel_column, want.pixel_color, out_item.pixel_color);
          errors++;
        end
        if (out_item.grid_last !== want.grid_last) begin
          $display("%0t: grid_last expected %0d actual %0d", $time,
                   want.grid_last, out_item.grid_last);
          errors++;
        end
      end
    end
  end

  initial begin
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    gaps_on   = 1'b1;
    mdl_phase = 1'b0;
    for (int k = 0; k < EDGE_COUNT; k++) begin
      mdl_edge[k]  = EDGE_RESET[k];
      mdl_sum[k]   = '0;
      mdl_level[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_bands();
    test_edge_extremes();
    test_random_traffic();
    quiesce();

    $display("Sent %0d bin words under %0d edge layouts, checked %0d pixels over %0d grids",
             bins_sent, edge_sets, pixels_seen, grids_expected);
    $display("Covered noise floor, ignored bins, extreme and unordered edges, idle gaps");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/sbbm_pkg.sv
rtl/core/sbbm_sqrt.sv
rtl/core/sbbm_datapath.sv
rtl/core/sbbm_ctrl.sv
rtl/core/spectrum_band_bar_meter.sv
tb/spectrum_band_bar_meter_tb.sv
